@@ rtl/tsm_pkg.sv @@
// ----------------------------------------------------------------------------
// tsm_pkg: shared types and functions for the transmitter symmetrization matrix
// Item and result structs, the quarter-step coefficient matrix, and the
// matrix selection and shift-add multiply helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tsm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int OUT_BITS    = SAMPLE_BITS + 4;
    localparam int NTX         = 5;
    localparam int QBITS       = 4;

    // transmitter counts
    localparam logic [2:0] CNT3 = 3'd3;
    localparam logic [2:0] CNT4 = 3'd4;
    localparam logic [2:0] CNT5 = 3'd5;
    localparam logic [2:0] CNT_RESET = CNT5;

    // health mask codes
    localparam logic [7:0] MASK_NONE   = 8'h00;
    localparam logic [7:0] MASK_ALL    = 8'hFF;
    localparam logic [7:0] MASK_ALL5   = 8'h1F;
    localparam logic [7:0] MASK_ALL4   = 8'h0F;
    localparam logic [7:0] MASK_ALL3   = 8'h07;
    localparam logic [7:0] MASK5_F1    = 8'h1E;
    localparam logic [7:0] MASK5_F2    = 8'h1D;
    localparam logic [7:0] MASK5_F3    = 8'h1B;
    localparam logic [7:0] MASK5_F4    = 8'h17;
    localparam logic [7:0] MASK5_F5    = 8'h0F;
    localparam logic [7:0] MASK4_F1    = 8'h0E;
    localparam logic [7:0] MASK4_F2    = 8'h0D;
    localparam logic [7:0] MASK4_F3    = 8'h0B;
    localparam logic [7:0] MASK4_F4    = 8'h07;

    typedef logic signed [QBITS-1:0]       coef_t;
    typedef coef_t [NTX-1:0]               sym_row_t;
    typedef sym_row_t [NTX-1:0]            sym_mat_t;

    typedef struct packed {
        logic [7:0]                    health_mask;
        logic signed [SAMPLE_BITS-1:0] phase_t1;
        logic signed [SAMPLE_BITS-1:0] phase_t2;
        logic signed [SAMPLE_BITS-1:0] phase_t3;
        logic signed [SAMPLE_BITS-1:0] phase_t4;
        logic signed [SAMPLE_BITS-1:0] phase_t5;
        logic signed [SAMPLE_BITS-1:0] atten_t1;
        logic signed [SAMPLE_BITS-1:0] atten_t2;
        logic signed [SAMPLE_BITS-1:0] atten_t3;
        logic signed [SAMPLE_BITS-1:0] atten_t4;
        logic signed [SAMPLE_BITS-1:0] atten_t5;
    } sym_in_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] sym_phase_t1;
        logic signed [OUT_BITS-1:0] sym_phase_t2;
        logic signed [OUT_BITS-1:0] sym_phase_t3;
        logic signed [OUT_BITS-1:0] sym_phase_t4;
        logic signed [OUT_BITS-1:0] sym_phase_t5;
        logic signed [OUT_BITS-1:0] sym_atten_t1;
        logic signed [OUT_BITS-1:0] sym_atten_t2;
        logic signed [OUT_BITS-1:0] sym_atten_t3;
        logic signed [OUT_BITS-1:0] sym_atten_t4;
        logic signed [OUT_BITS-1:0] sym_atten_t5;
    } sym_out_t;

    // classified item: coefficient matrix plus the samples
    typedef struct packed {
        sym_mat_t mat;
        sym_in_t  smp;
    } sym_job_t;

    function automatic sym_row_t mk_row(input int a, input int b, input int c,
                                        input int d, input int e);
        sym_row_t r;
        r[0] = QBITS'(a);
        r[1] = QBITS'(b);
        r[2] = QBITS'(c);
        r[3] = QBITS'(d);
        r[4] = QBITS'(e);
        return r;
    endfunction

    function automatic sym_mat_t mk_mat(input sym_row_t r0, input sym_row_t r1,
                                        input sym_row_t r2, input sym_row_t r3,
                                        input sym_row_t r4);
        sym_mat_t m;
        m[0] = r0;
        m[1] = r1;
        m[2] = r2;
        m[3] = r3;
        m[4] = r4;
        return m;
    endfunction

    // diagonal of the working bits; identity for an empty mask or three units
    function automatic sym_mat_t diag_mat(input logic [2:0] count, input logic [7:0] mask);
        sym_mat_t m;
        m = '0;
        for (int r = 0; r < NTX; r++)
        begin
            if (mask == MASK_NONE || count == CNT3 || mask[r])
                m[r][r] = QBITS'(4);
        end
        return m;
    endfunction

    // select the matrix, then drop rows and columns of absent transmitters
    function automatic sym_mat_t sym_pick(input logic [2:0] count, input logic [7:0] mask);
        sym_mat_t m;
        m = diag_mat(count, mask);
        case (count)
            CNT5:
            begin
                case (mask)
                    MASK_ALL5, MASK_ALL: m = mk_mat(mk_row(3,2,-1,0,0), mk_row(1,2,1,0,0),
                        mk_row(0,1,2,1,0), mk_row(0,0,1,2,1), mk_row(0,0,-1,2,3));
                    MASK5_F1: m = mk_mat(mk_row(0,5,2,-3,0), mk_row(0,3,2,-1,0),
                        mk_row(0,1,2,1,0), mk_row(0,0,1,2,1), mk_row(0,0,-1,2,3));
                    MASK5_F2: m = mk_mat(mk_row(5,0,-3,2,0), mk_row(3,0,-1,2,0),
                        mk_row(0,0,3,2,-1), mk_row(0,0,1,2,1), mk_row(0,0,-1,2,3));
                    MASK5_F3: m = mk_mat(mk_row(2,3,0,-1,0), mk_row(0,5,0,-3,2),
                        mk_row(0,3,0,-1,2), mk_row(0,1,0,1,2), mk_row(0,-1,0,3,2));
                    MASK5_F4: m = mk_mat(mk_row(3,2,-1,0,0), mk_row(1,2,1,0,0),
                        mk_row(-1,2,3,0,0), mk_row(0,2,-1,0,3), mk_row(0,2,-3,0,5));
                    MASK5_F5: m = mk_mat(mk_row(3,2,-1,0,0), mk_row(1,2,1,0,0),
                        mk_row(2,1,2,1,0), mk_row(0,-1,2,3,0), mk_row(0,-3,2,5,0));
                    default: m = diag_mat(count, mask);
                endcase
            end
            CNT4:
            begin
                case (mask)
                    MASK_ALL4, MASK_ALL: m = mk_mat(mk_row(3,2,-1,0,0), mk_row(1,2,1,0,0),
                        mk_row(0,1,2,1,0), mk_row(0,-1,2,3,0), mk_row(0,0,0,0,0));
                    MASK4_F1: m = mk_mat(mk_row(0,5,2,-3,0), mk_row(0,3,2,-1,0),
                        mk_row(0,1,2,1,0), mk_row(0,-1,2,3,0), mk_row(0,0,0,0,0));
                    MASK4_F2: m = mk_mat(mk_row(5,0,-3,2,0), mk_row(3,0,-1,2,0),
                        mk_row(1,0,1,2,0), mk_row(-1,0,3,2,0), mk_row(0,0,0,0,0));
                    MASK4_F3: m = mk_mat(mk_row(2,3,0,-1,0), mk_row(2,1,0,1,0),
                        mk_row(2,-1,0,3,0), mk_row(-2,-3,0,5,0), mk_row(0,0,0,0,0));
                    MASK4_F4: m = mk_mat(mk_row(3,2,-1,0,0), mk_row(1,2,1,0,0),
                        mk_row(-1,2,3,0,0), mk_row(-3,2,5,0,0), mk_row(0,0,0,0,0));
                    default: m = diag_mat(count, mask);
                endcase
            end
            CNT3:
            begin
                case (mask)
                    MASK_ALL3, MASK_ALL: m = mk_mat(mk_row(3,2,-1,0,0), mk_row(1,2,1,0,0),
                        mk_row(-1,2,3,0,0), mk_row(0,0,0,0,0), mk_row(0,0,0,0,0));
                    default: m = diag_mat(count, mask);
                endcase
            end
            default: m = '0;
        endcase
        for (int r = 0; r < NTX; r++)
        begin
            for (int c = 0; c < NTX; c++)
            begin
                if (3'(r) >= count || 3'(c) >= count)
                    m[r][c] = '0;
            end
        end
        return m;
    endfunction

    // quarter count times a Q16.8 sample, by shift and add, giving Q18.10
    function automatic logic signed [OUT_BITS-1:0] qmul(input coef_t q,
                                                        input logic signed [SAMPLE_BITS-1:0] x);
        logic signed [OUT_BITS-1:0] xe;
        logic signed [OUT_BITS-1:0] t0;
        logic signed [OUT_BITS-1:0] t1;
        logic signed [OUT_BITS-1:0] t2;
        logic signed [OUT_BITS-1:0] t3;
        xe = {{(OUT_BITS-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
        t0 = q[0] ? xe : '0;
        t1 = q[1] ? (xe <<< 1) : '0;
        t2 = q[2] ? (xe <<< 2) : '0;
        t3 = q[3] ? (xe <<< 3) : '0;
        return t0 + t1 + t2 - t3;
    endfunction

endpackage

`default_nettype wire

@@ rtl/transmitter_symmetrization_matrix_top.sv @@
// ----------------------------------------------------------------------------
// transmitter_symmetrization_matrix_top: transmitter symmetrization matrix
// Path: an accepted item loads the intake register on the accepting edge, then
// passes the queue, product stage and row-sum/result register, where done rises.
// Throughput: one item per cycle; the result side cannot stall, so busy stays low.
// Reset: asynchronous active-low; clears all valid flags and the queue, and
// sets active_transmitters to 5.
// ----------------------------------------------------------------------------
`default_nettype none

module transmitter_symmetrization_matrix_top
    import tsm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_data,
    input  wire logic       start,
    input  wire sym_in_t    item,
    output logic            busy,
    output logic            done,
    output sym_out_t        result
);

    logic [2:0] count_reg;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    sym_job_t   front_job;
    sym_job_t   back_job;

    // active_transmitters register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= CNT_RESET;
        else if (cfg_we)
            count_reg <= cfg_data;
    end

    tsm_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .count  (count_reg),
        .q_full (q_full),
        .busy   (busy),
        .push   (push),
        .job    (front_job)
    );

    tsm_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (front_job),
        .pop    (pop),
        .full   (q_full),
        .empty  (q_empty),
        .rd_job (back_job)
    );

    tsm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .job     (back_job),
        .pop     (pop),
        .done    (done),
        .result  (result)
    );

endmodule

`default_nettype wire

@@ rtl/tsm_front.sv @@
// ----------------------------------------------------------------------------
// tsm_front: item intake and classification
// Takes an item, picks its coefficient matrix from the transmitter count and
// health mask, and holds the classified item until the queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tsm_front
    import tsm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire sym_in_t    item,
    input  wire logic [2:0] count,
    input  wire logic       q_full,
    output logic            busy,
    output logic            push,
    output sym_job_t        job
);

    logic     vld_reg;
    logic     vld_next;
    sym_job_t job_reg;
    logic     accept;

    // stage holds one item; it frees when the queue has room
    assign push   = vld_reg && !q_full;
    assign busy   = vld_reg && q_full;
    assign accept = start && !busy;
    assign job    = job_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
            vld_next = 1'b1;
        else if (push)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // classification: matrix chosen at intake
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg.mat <= sym_pick(count, item.health_mask);
            job_reg.smp <= item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tsm_queue.sv @@
// ----------------------------------------------------------------------------
// tsm_queue: two-entry item queue
// Decouples classification from the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tsm_queue
    import tsm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire sym_job_t wr_job,
    input  wire logic     pop,
    output logic          full,
    output logic          empty,
    output sym_job_t      rd_job
);

    localparam int DEPTH = 2;

    sym_job_t   mem [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full   = (cnt_reg == 2'(DEPTH));
    assign empty  = (cnt_reg == 2'd0);
    assign rd_job = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = ~wr_ptr_reg;
        if (pop)
            rd_ptr_next = ~rd_ptr_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry write
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue read while empty");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

@@ rtl/tsm_back.sv @@
// ----------------------------------------------------------------------------
// tsm_back: matrix-vector arithmetic
// Stage one forms the 50 quarter-step products by shift-add; stage two sums
// each row and registers the result with its strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module tsm_back
    import tsm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     q_empty,
    input  wire sym_job_t job,
    output logic          pop,
    output logic          done,
    output sym_out_t      result
);

    typedef logic signed [OUT_BITS-1:0] acc_t;

    logic signed [SAMPLE_BITS-1:0] ph [NTX];
    logic signed [SAMPLE_BITS-1:0] at [NTX];
    acc_t     pp_reg [NTX][NTX];
    acc_t     pa_reg [NTX][NTX];
    acc_t     sp [NTX];
    acc_t     sa [NTX];
    logic     prod_vld_reg;
    logic     done_reg;
    sym_out_t res_reg;

    // output side never stalls, so take an item whenever one waits
    assign pop    = !q_empty;
    assign done   = done_reg;
    assign result = res_reg;

    assign ph[0] = job.smp.phase_t1;
    assign ph[1] = job.smp.phase_t2;
    assign ph[2] = job.smp.phase_t3;
    assign ph[3] = job.smp.phase_t4;
    assign ph[4] = job.smp.phase_t5;
    assign at[0] = job.smp.atten_t1;
    assign at[1] = job.smp.atten_t2;
    assign at[2] = job.smp.atten_t3;
    assign at[3] = job.smp.atten_t4;
    assign at[4] = job.smp.atten_t5;

    // stage one: products
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < NTX; r++)
        begin
            for (int c = 0; c < NTX; c++)
            begin
                pp_reg[r][c] <= qmul(job.mat[r][c], ph[c]);
                pa_reg[r][c] <= qmul(job.mat[r][c], at[c]);
            end
        end
    end

    // row sums
    always_comb
    begin
        for (int r = 0; r < NTX; r++)
        begin
            sp[r] = pp_reg[r][0] + pp_reg[r][1] + pp_reg[r][2] + pp_reg[r][3] + pp_reg[r][4];
            sa[r] = pa_reg[r][0] + pa_reg[r][1] + pa_reg[r][2] + pa_reg[r][3] + pa_reg[r][4];
        end
    end

    // stage two: result register
    always_ff @(posedge clk)
    begin
        res_reg.sym_phase_t1 <= sp[0];
        res_reg.sym_phase_t2 <= sp[1];
        res_reg.sym_phase_t3 <= sp[2];
        res_reg.sym_phase_t4 <= sp[3];
        res_reg.sym_phase_t5 <= sp[4];
        res_reg.sym_atten_t1 <= sa[0];
        res_reg.sym_atten_t2 <= sa[1];
        res_reg.sym_atten_t3 <= sa[2];
        res_reg.sym_atten_t4 <= sa[3];
        res_reg.sym_atten_t5 <= sa[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= pop;
            done_reg     <= prod_vld_reg;
        end
    end

    a_done_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> ##2 done)
        else $error("popped item did not reach the result two cycles later");

    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(prod_vld_reg))
        else $error("result strobe without an item in the product stage");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: transmitter symmetrization matrix
// Drives health masks and phase/attenuation samples through the block under
// transmitter counts three to five and out-of-range counts, predicts each
// symmetrized result with a private copy of the quarter-step coefficient
// tables, and compares every result field by field. Directed items first,
// then random items under three sender idling profiles.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import tsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam int NFIELDS = 2 * NTX;
    localparam int RANDOM_PER_COUNT = 70;

    // every mask that has a meaning for some transmitter count
    localparam logic [7:0] NAMED_MASKS [14] = '{
        MASK_NONE, MASK_ALL, MASK_ALL5, MASK_ALL4, MASK_ALL3,
        MASK5_F1, MASK5_F2, MASK5_F3, MASK5_F4, MASK5_F5,
        MASK4_F1, MASK4_F2, MASK4_F3, MASK4_F4
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_data;
    logic       start;
    sym_in_t    item;
    logic       busy;
    logic       done;
    sym_out_t   result;

    logic [2:0] tx_count;
    int         sender_idle_pct;
    int         error_count;
    sym_out_t   expected_results [$];
    sym_out_t   want;
    logic [OUT_BITS-1:0] got_field;
    logic [OUT_BITS-1:0] want_field;

    string result_field_names [NFIELDS] = '{
        "sym_phase_t1", "sym_phase_t2", "sym_phase_t3", "sym_phase_t4", "sym_phase_t5",
        "sym_atten_t1", "sym_atten_t2", "sym_atten_t3", "sym_atten_t4", "sym_atten_t5"
    };

    transmitter_symmetrization_matrix_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .start    (start),
        .item     (item),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // coefficient in quarters for row r, column c
    function automatic int sym_coef(input logic [2:0] count, input logic [7:0] mask,
                                    input int r, input int c);
        int  m [25];
        bit  hit;
        hit = 1'b1;
        if (count < CNT3 || count > CNT5 || r >= count || c >= count)
            return 0;
        case (count)
            CNT5:
            begin
                case (mask)
                    MASK_ALL5, MASK_ALL:
                        m = '{3,2,-1,0,0, 1,2,1,0,0, 0,1,2,1,0, 0,0,1,2,1, 0,0,-1,2,3};
                    MASK5_F1:
                        m = '{0,5,2,-3,0, 0,3,2,-1,0, 0,1,2,1,0, 0,0,1,2,1, 0,0,-1,2,3};
                    MASK5_F2:
                        m = '{5,0,-3,2,0, 3,0,-1,2,0, 0,0,3,2,-1, 0,0,1,2,1, 0,0,-1,2,3};
                    MASK5_F3:
                        m = '{2,3,0,-1,0, 0,5,0,-3,2, 0,3,0,-1,2, 0,1,0,1,2, 0,-1,0,3,2};
                    MASK5_F4:
                        m = '{3,2,-1,0,0, 1,2,1,0,0, -1,2,3,0,0, 0,2,-1,0,3, 0,2,-3,0,5};
                    MASK5_F5:
                        m = '{3,2,-1,0,0, 1,2,1,0,0, 2,1,2,1,0, 0,-1,2,3,0, 0,-3,2,5,0};
                    default: hit = 1'b0;
                endcase
            end
            CNT4:
            begin
                case (mask)
                    MASK_ALL4, MASK_ALL:
                        m = '{3,2,-1,0,0, 1,2,1,0,0, 0,1,2,1,0, 0,-1,2,3,0, 0,0,0,0,0};
                    MASK4_F1:
                        m = '{0,5,2,-3,0, 0,3,2,-1,0, 0,1,2,1,0, 0,-1,2,3,0, 0,0,0,0,0};
                    MASK4_F2:
                        m = '{5,0,-3,2,0, 3,0,-1,2,0, 1,0,1,2,0, -1,0,3,2,0, 0,0,0,0,0};
                    MASK4_F3:
                        m = '{2,3,0,-1,0, 2,1,0,1,0, 2,-1,0,3,0, -2,-3,0,5,0, 0,0,0,0,0};
                    MASK4_F4:
                        m = '{3,2,-1,0,0, 1,2,1,0,0, -1,2,3,0,0, -3,2,5,0,0, 0,0,0,0,0};
                    default: hit = 1'b0;
                endcase
            end
            default:
            begin
                case (mask)
                    MASK_ALL3, MASK_ALL:
                        m = '{3,2,-1,0,0, 1,2,1,0,0, -1,2,3,0,0, 0,0,0,0,0, 0,0,0,0,0};
                    default: hit = 1'b0;
                endcase
            end
        endcase
        // no table entry: identity for an empty mask or three units, else working bits
        if (!hit)
            return (r == c && (mask == MASK_NONE || count == CNT3 || mask[r])) ? 4 : 0;
        return m[r * NTX + c];
    endfunction

    // symmetrized phases and attenuations for one item
    function automatic sym_out_t predict_result(input logic [2:0] count, input sym_in_t x);
        longint   ph [NTX];
        longint   at [NTX];
        longint   sp;
        longint   sa;
        logic signed [OUT_BITS-1:0] po [NTX];
        logic signed [OUT_BITS-1:0] ao [NTX];
        sym_out_t y;
        ph = '{$signed(x.phase_t1), $signed(x.phase_t2), $signed(x.phase_t3),
               $signed(x.phase_t4), $signed(x.phase_t5)};
        at = '{$signed(x.atten_t1), $signed(x.atten_t2), $signed(x.atten_t3),
               $signed(x.atten_t4), $signed(x.atten_t5)};
        for (int r = 0; r < NTX; r++)
        begin
            sp = 0;
            sa = 0;
            for (int c = 0; c < NTX; c++)
            begin
                sp += sym_coef(count, x.health_mask, r, c) * ph[c];
                sa += sym_coef(count, x.health_mask, r, c) * at[c];
            end
            po[r] = OUT_BITS'(sp);
            ao[r] = OUT_BITS'(sa);
        end
        y = {po[0], po[1], po[2], po[3], po[4], ao[0], ao[1], ao[2], ao[3], ao[4]};
        return y;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        int v;
        case ($urandom_range(0, 5))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2:
            begin
                v = int'($urandom_range(0, 511)) - 256;
                return SAMPLE_BITS'(v);
            end
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // half the masks come from the named set, the rest are any byte
    function automatic logic [7:0] random_mask();
        if ($urandom_range(0, 1) == 1)
            return NAMED_MASKS[$urandom_range(0, 13)];
        return 8'($urandom());
    endfunction

    function automatic sym_in_t random_item(input logic [7:0] mask);
        sym_in_t x;
        x.health_mask = mask;
        x.phase_t1 = rand_sample();
        x.phase_t2 = rand_sample();
        x.phase_t3 = rand_sample();
        x.phase_t4 = rand_sample();
        x.phase_t5 = rand_sample();
        x.atten_t1 = rand_sample();
        x.atten_t2 = rand_sample();
        x.atten_t3 = rand_sample();
        x.atten_t4 = rand_sample();
        x.atten_t5 = rand_sample();
        return x;
    endfunction

    // present one item and hold it until accepted
    task automatic send_item(input sym_in_t x);
        start <= 1'b1;
        item  <= x;
        do
            @(posedge clk);
        while (busy);
        expected_results.push_back(predict_result(tx_count, x));
    endtask

    task automatic maybe_idle();
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // register write once the pipeline has emptied
    task automatic set_transmitter_count(input logic [2:0] count);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= count;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tx_count = count;
    endtask

    task automatic send_masks(input logic [7:0] masks [$]);
        foreach (masks[i])
        begin
            send_item(random_item(masks[i]));
            maybe_idle();
        end
    endtask

    // reset count of five: all named masks, empty mask, a diagonal mask
    task automatic test_reset_count();
        send_masks('{MASK_ALL5, MASK_ALL, MASK5_F1, MASK5_F2, MASK5_F3, MASK5_F4,
                     MASK5_F5, MASK_NONE, 8'h15});
    endtask

    task automatic test_four_transmitters();
        set_transmitter_count(CNT4);
        send_masks('{MASK_ALL4, MASK4_F1, MASK4_F2, MASK4_F3, MASK4_F4, 8'hA5});
    endtask

    task automatic test_three_transmitters();
        set_transmitter_count(CNT3);
        send_masks('{MASK_ALL3, MASK_ALL, 8'h05});
    endtask

    // counts outside three to five give all-zero results
    task automatic test_count_out_of_range();
        set_transmitter_count(3'd0);
        send_masks('{MASK_ALL});
        set_transmitter_count(3'd7);
        send_masks('{MASK_ALL5});
    endtask

    // full-scale samples through the largest coefficients
    task automatic test_extremes();
        sym_in_t x;
        set_transmitter_count(CNT5);
        x = random_item(MASK_ALL);
        {x.phase_t1, x.phase_t2, x.phase_t3, x.phase_t4, x.phase_t5,
         x.atten_t1, x.atten_t2, x.atten_t3, x.atten_t4, x.atten_t5} = {NFIELDS{SMP_MAX}};
        send_item(x);
        {x.phase_t1, x.phase_t2, x.phase_t3, x.phase_t4, x.phase_t5,
         x.atten_t1, x.atten_t2, x.atten_t3, x.atten_t4, x.atten_t5} = {NFIELDS{SMP_MIN}};
        x.health_mask = MASK5_F4;
        send_item(x);
        {x.phase_t1, x.phase_t2, x.phase_t3, x.phase_t4, x.phase_t5,
         x.atten_t1, x.atten_t2, x.atten_t3, x.atten_t4, x.atten_t5} =
            {SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN,
             SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX};
        x.health_mask = MASK5_F1;
        send_item(x);
    endtask

    // random items under counts five, three, four and one random count, one idling profile
    task automatic test_random(input int idle_pct);
        logic [2:0] counts [4];
        sender_idle_pct = idle_pct;
        counts = '{CNT5, CNT3, CNT4, 3'($urandom_range(0, 7))};
        foreach (counts[k])
        begin
            set_transmitter_count(counts[k]);
            repeat (RANDOM_PER_COUNT)
            begin
                send_item(random_item(random_mask()));
                maybe_idle();
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected: expected none, actual %h",
                         $time, result);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                for (int k = 0; k < NFIELDS; k++)
                begin
                    got_field  = result[(NFIELDS - 1 - k) * OUT_BITS +: OUT_BITS];
                    want_field = want[(NFIELDS - 1 - k) * OUT_BITS +: OUT_BITS];
                    if (got_field !== want_field)
                    begin
                        $display("%0t: %s mismatch: expected %h, actual %h", $time,
                                 result_field_names[k], want_field, got_field);
                        error_count++;
                    end
                end
            end
        end
    end

    // main sequence
    initial
    begin
        error_count     = 0;
        sender_idle_pct = 18;
        tx_count        = CNT_RESET;
        rst_n    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        start    <= 1'b0;
        item     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_count();
        test_four_transmitters();
        test_three_transmitters();
        test_count_out_of_range();
        test_extremes();
        test_random(18);
        test_random(57);
        test_random(0);

        drain();
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/tsm_pkg.sv
rtl/tsm_front.sv
rtl/tsm_queue.sv
rtl/tsm_back.sv
rtl/transmitter_symmetrization_matrix_top.sv
verif/testbench.sv
